>>> hdl/rrcs_pkg.sv
// Shared types, constants and defaults of the round-robin CPU scheduler.
package rrcs_pkg;

  localparam int unsigned NumCpusDefault    = 4;
  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned ThreadBitsDefault = 8;

  localparam int unsigned CpuW    = 2;
  localparam int unsigned TidW    = 8;
  localparam int unsigned SliceW  = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutW    = 16;

  localparam logic [SliceW-1:0] SliceReset = SliceW'(10);

  typedef enum logic [CmdW-1:0] {
    CMD_SCHED = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READY = 2'd2
  } cmd_e;

  // Packed from the most significant field down; out_cpu sits in the lowest bits.
  typedef struct packed {
    logic            overflow;
    logic [CpuW-1:0] wake_cpu;
    logic            wake_valid;
    logic            switched;
    logic            idle;
    logic [TidW-1:0] running;
    logic [CpuW-1:0] out_cpu;
  } result_t;

endpackage

>>> hdl/round_robin_cpu_scheduler_core.sv
// Round-robin CPU scheduler: ready queue, per-CPU slice state and result buffer.
//
// Usage:
//   Events enter on the s_axis channel: tuser carries the command (schedule
//   call, timer tick, thread ready), tdata the CPU index, the flag and the
//   thread id. Every accepted event gives exactly one result on m_axis:
//   the CPU's thread and idle state, whether it switched, a CPU to wake and
//   the queue overflow flag.
//   An event takes effect at the edge that accepts it; its result is registered
//   before m_axis. One event is taken per cycle while s_axis_tready is high.
//   The head of the ready queue is kept in a registered read of the queue
//   memory, addressed by the next head pointer, so a pop needs no wait.
//   A two-entry output buffer keeps s_axis_tready high while one result
//   waits; s_axis_tready falls only when both entries are held by a
//   stalled receiver, and rises again once m_axis_tready takes one.
//   The slice length is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while the block is idle (not enforced); it resets to 10 ticks.
//   Reset empties the queue and the output buffer and idles every CPU.
//   Queue entries hold no reset value; only written entries are read.
module round_robin_cpu_scheduler_core
  import rrcs_pkg::*;
#(
  parameter int unsigned NUM_CPUS    = NumCpusDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned THREAD_BITS = ThreadBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SliceW-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [1:0] cpu, [2] flag, [10:3] thread, [15:11] zero
  input  logic [InDataW-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [CmdW-1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [1:0] out_cpu, [9:2] running, [10] idle, [11] switched,
  // [12] wake_valid, [14:13] wake_cpu, [15] overflow
  output logic [OutW-1:0]    m_axis_tdata
);

  localparam int unsigned NumSlots = (NUM_CPUS < 4) ? NUM_CPUS : 4;
  localparam int unsigned SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

  typedef logic [THREAD_BITS-1:0] thr_t;

  logic [SliceW-1:0] slice_q;

  thr_t              fifo_mem [QUEUE_DEPTH];
  thr_t              head_data_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;

  thr_t              thr_q   [NumSlots];
  logic              idle_q  [NumSlots];
  logic [SliceW-1:0] ticks_q [NumSlots];

  thr_t              thr_new;
  logic              idle_new;
  logic [SliceW-1:0] ticks_new;
  logic              slot_we;

  logic              push_en, pop_en;
  thr_t              push_data;

  logic              s_fire;
  logic [CpuW-1:0]   in_cpu;
  logic              in_flag;
  logic [TidW-1:0]   in_thread;
  thr_t              tid;
  logic              valid_cpu;
  logic [SlotW-1:0]  slot;
  logic              q_nonempty;
  result_t           res;

  result_t           out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              out_pop;

  assign in_cpu     = s_axis_tdata[CpuW-1:0];
  assign in_flag    = s_axis_tdata[CpuW];
  assign in_thread  = s_axis_tdata[CpuW+TidW:CpuW+1];
  assign tid        = THREAD_BITS'(16'(in_thread));
  assign valid_cpu  = (32'(in_cpu) < NUM_CPUS);
  assign slot       = SlotW'(in_cpu);
  assign q_nonempty = (count_q != '0);

  assign s_axis_tready = !skid_valid_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_en        = 1'b0;
    pop_en         = 1'b0;
    push_data      = tid;
    slot_we        = 1'b0;
    thr_new        = thr_q[slot];
    idle_new       = idle_q[slot];
    ticks_new      = ticks_q[slot];
    res            = '0;
    res.out_cpu    = in_cpu;

    case (cmd_e'(s_axis_tuser))
      CMD_READY: begin
        if (count_q == FullCount) begin
          res.overflow = 1'b1;
        end else begin
          push_en = 1'b1;
        end
      end
      CMD_SCHED: begin
        if (valid_cpu && in_flag) begin
          slot_we = 1'b1;
          if (q_nonempty) begin
            pop_en    = 1'b1;
            thr_new   = head_data_q;
            idle_new  = 1'b0;
            ticks_new = slice_q;
          end else begin
            thr_new  = '0;
            idle_new = 1'b1;
          end
          res.switched = (idle_new != idle_q[slot]) || (thr_new != thr_q[slot]);
        end
      end
      CMD_TICK: begin
        if (valid_cpu && in_flag) begin
          slot_we   = 1'b1;
          ticks_new = slice_q;
        end else if (valid_cpu && !idle_q[slot]) begin
          slot_we = 1'b1;
          if (ticks_q[slot] <= SliceW'(1)) begin
            if (q_nonempty) begin
              pop_en       = 1'b1;
              push_en      = 1'b1;
              push_data    = thr_q[slot];
              thr_new      = head_data_q;
              res.switched = (head_data_q != thr_q[slot]);
            end
            ticks_new = slice_q;
          end else begin
            ticks_new = ticks_q[slot] - SliceW'(1);
          end
          if (q_nonempty) begin
            for (int k = NumSlots - 1; k >= 0; k--) begin
              if (idle_q[k]) begin
                res.wake_valid = 1'b1;
                res.wake_cpu   = CpuW'(k);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (valid_cpu) begin
      res.idle    = idle_new;
      res.running = idle_new ? '0 : TidW'(16'(thr_new));
    end else begin
      res.idle    = 1'b1;
      res.running = '0;
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (s_fire && pop_en) begin
      head_d = (head_q == LastSlot) ? '0 : head_q + PtrW'(1);
    end
    if (s_fire && push_en) begin
      tail_d = (tail_q == LastSlot) ? '0 : tail_q + PtrW'(1);
    end
    if (s_fire && push_en && !pop_en) begin
      count_d = count_q + CntW'(1);
    end else if (s_fire && pop_en && !push_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && push_en) begin
      fifo_mem[tail_q] <= push_data;
    end
    if (s_fire && push_en && (tail_q == head_d)) begin
      head_data_q <= push_data;
    end else begin
      head_data_q <= fifo_mem[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SliceReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      for (int k = 0; k < NumSlots; k++) begin
        thr_q[k]   <= '0;
        idle_q[k]  <= 1'b1;
        ticks_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        slice_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (s_fire && slot_we) begin
        thr_q[slot]   <= thr_new;
        idle_q[slot]  <= idle_new;
        ticks_q[slot] <= ticks_new;
      end
    end
  end

  assign out_pop = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (s_fire) begin
        if (!out_valid_q || out_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (s_fire) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
